// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

	localparam int unsigned NumRegs = 6;
	localparam int unsigned DivBits = 32;
	localparam int unsigned DivSideW = 66;

	typedef enum logic [2:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4,
		REG_OSS     = 3'd5
	} reg_index_t;

	localparam logic [31:0] B6Offset   = 32'd4000;
	localparam logic [31:0] C3038      = 32'd3038;
	localparam logic [31:0] CNeg7357   = 32'hFFFF_E343;
	localparam logic [31:0] C3791      = 32'd3791;
	localparam logic [31:0] C50000     = 32'd50000;
	localparam logic [31:0] C32768     = 32'd32768;
	localparam logic [31:0] SignBit    = 32'h8000_0000;
	localparam logic [15:0] AllOnes16  = 16'hFFFF;
	localparam logic [19:0] PressMax   = 20'hFFFFF;

	// Fields of one division slot, carried beside every divider stage.
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] den;
	} div_t;

	function automatic logic [31:0] sx16(input logic [15:0] h);
		sx16 = {{16{h[15]}}, h};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		asr = 32'($signed(v) >>> n);
	endfunction

	function automatic logic bad_half(input logic [15:0] h);
		bad_half = (h == 16'd0) || (h == AllOnes16);
	endfunction

	// One restoring step of unsigned division: bit k of the quotient.
	function automatic div_t div_step(input div_t d, input logic nb);
		logic [32:0] trial;
		div_t r;
		trial = {d.rem, nb} - {1'b0, d.den};
		r = d;
		if (!trial[32]) begin
			r.rem = trial[31:0];
			r.quo = {d.quo[30:0], 1'b1};
		end else begin
			r.rem = {d.rem[30:0], nb};
			r.quo = {d.quo[30:0], 1'b0};
		end
		div_step = r;
	endfunction

endpackage

// ----- rtl/bsc_div.sv -----
module bsc_div
	import bsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         num,
	input  logic [31:0]         den,
	input  logic [DivSideW-1:0] side_in,
	output logic                out_valid,
	output logic [31:0]         quo,
	output logic [DivSideW-1:0] side_out
);

	div_t                d_q    [DivBits+1];
	logic [31:0]         n_q    [DivBits+1];
	logic [DivSideW-1:0] side_q [DivBits+1];
	logic [DivBits:0]    v_q;

	always_comb begin
		d_q[0]    = '{rem: 32'd0, quo: 32'd0, den: den};
		n_q[0]    = num;
		side_q[0] = side_in;
		v_q[0]    = in_valid;
	end

	for (genvar k = 0; k < DivBits; k++) begin : g_st
		div_t                d_s1;
		logic [31:0]         n_s1;
		logic [DivSideW-1:0] sd_s1;
		logic                v_s1;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
			end else if (en) begin
				v_s1 <= v_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s1  <= div_step(d_q[k], n_q[k][31]);
				n_s1  <= {n_q[k][30:0], 1'b0};
				sd_s1 <= side_q[k];
			end
		end
		always_comb begin
			d_q[k+1]    = d_s1;
			n_q[k+1]    = n_s1;
			side_q[k+1] = sd_s1;
			v_q[k+1]    = v_s1;
		end
	end

	assign out_valid = v_q[DivBits];
	assign quo       = d_q[DivBits].quo;
	assign side_out  = side_q[DivBits];

endmodule

// ----- rtl/barometric_sensor_compensation_unit.sv -----
// Barometric compensation pipeline. Each transaction carries one raw
// temperature word and three raw pressure bytes and yields one result with
// temperature in 0.1 degC, pressure in Pa and a calibration flag on tuser.
// A new transaction is accepted every cycle while the output is not stalled.
// The pipeline has 74 register stages; two 32-stage bit-per-stage dividers
// in series (temperature, then pressure) make up most of them.
// A stall at the output freezes the whole pipeline without loss.
module barometric_sensor_compensation_unit
	import bsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure_bytes[39:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // temperature_tenths[15:0], pressure_pascal[35:16],
	                               // zeros above
	output logic        m_tuser    // calibration_invalid[0]
);

	logic [31:0] r_q [NumRegs-1];
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs - 1; i++) r_q[i] <= 32'd0;
			oss_q <= 2'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_AC1_AC2: r_q[0] <= cfg_data;
				REG_AC3_AC4: r_q[1] <= cfg_data;
				REG_AC5_AC6: r_q[2] <= cfg_data;
				REG_B1_B2:   r_q[3] <= cfg_data;
				REG_MC_MD:   r_q[4] <= cfg_data;
				REG_OSS:     oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic        invalid;
	always_comb begin
		ac1 = sx16(r_q[0][31:16]); ac2 = sx16(r_q[0][15:0]);
		ac3 = sx16(r_q[1][31:16]); ac4 = {16'd0, r_q[1][15:0]};
		ac5 = {16'd0, r_q[2][31:16]}; ac6 = {16'd0, r_q[2][15:0]};
		b1 = sx16(r_q[3][31:16]); b2 = sx16(r_q[3][15:0]);
		mc = sx16(r_q[4][31:16]); md = sx16(r_q[4][15:0]);
		invalid = 1'b0;
		for (int i = 0; i < NumRegs - 1; i++)
			invalid = invalid | bad_half(r_q[i][31:16]) | bad_half(r_q[i][15:0]);
	end

	// Global enable: advance when the output slot is free or being taken.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: capture and compute (UT - AC6) * AC5 >>> 15, align UP.
	logic        v_s1;
	logic [31:0] x1_s1, up_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= asr(({16'd0, s_tdata[15:0]} - ac6) * ac5, 15);
			up_s1 <= {8'd0, s_tdata[39:16]} >> (4'd8 - {2'd0, oss_q});
		end
	end

	// Stage 2: signed divide operands, magnitudes and sign.
	logic        v_s2, neg_s2, dz_s2;
	logic [31:0] na_s2, nb_s2, x1_s2, up_s2;
	logic [31:0] sa, sb;
	always_comb begin
		sa = mc << 11;
		sb = x1_s1 + md;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			na_s2  <= sa[31] ? 32'(-sa) : sa;
			nb_s2  <= sb[31] ? 32'(-sb) : sb;
			neg_s2 <= sa[31] ^ sb[31];
			dz_s2  <= (sb == 32'd0);
			x1_s2  <= x1_s1;
			up_s2  <= up_s1;
		end
	end

	logic                tdv;
	logic [31:0]         tq;
	logic [DivSideW-1:0] tside;
	bsc_div u_tdiv (
		.clk, .arst_n, .en,
		.in_valid (v_s2), .num (na_s2), .den (nb_s2),
		.side_in  ({dz_s2, neg_s2, x1_s2, up_s2}),
		.out_valid(tdv), .quo (tq), .side_out (tside)
	);

	// Stage 3: B5.
	logic        v_s3;
	logic [31:0] b5_s3, up_s3;
	logic [31:0] x2t;
	always_comb begin
		if (tside[65]) x2t = 32'hFFFF_FFFF;
		else if (tside[64]) x2t = 32'(-tq);
		else x2t = tq;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= tdv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b5_s3 <= tside[63:32] + x2t;
			up_s3 <= tside[31:0];
		end
	end

	// Stage 4: B6 products.
	logic        v_s4;
	logic [31:0] sq_s4, p1_s4, p2_s4, b5_s4, up_s4;
	logic [31:0] b6;
	assign b6 = b5_s3 - B6Offset;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4 <= asr(b6 * b6, 12);
			p1_s4 <= asr(ac2 * b6, 11);
			p2_s4 <= asr(ac3 * b6, 13);
			b5_s4 <= b5_s3;
			up_s4 <= up_s3;
		end
	end

	// Stage 5: squared-term products.
	logic        v_s5;
	logic [31:0] x1p_s5, x2p_s5, p1_s5, p2_s5, b5_s5, up_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1p_s5 <= asr(b2 * sq_s4, 11);
			x2p_s5 <= asr(b1 * sq_s4, 16);
			p1_s5  <= p1_s4;
			p2_s5  <= p2_s4;
			b5_s5  <= b5_s4;
			up_s5  <= up_s4;
		end
	end

	// Stage 6: B3 and X3 for B4.
	logic        v_s6;
	logic [31:0] b3_s6, x3_s6, b5_s6, up_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b3_s6 <= asr(((ac1 * 32'd4 + x1p_s5 + p1_s5) << oss_q) + 32'd2, 2);
			x3_s6 <= asr(p2_s5 + x2p_s5 + 32'd2, 2);
			b5_s6 <= b5_s5;
			up_s6 <= up_s5;
		end
	end

	// Stage 7: B4 and B7.
	logic        v_s7;
	logic [31:0] b4_s7, b7_s7, b5_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s7 <= (ac4 * (x3_s6 + C32768)) >> 15;
			b7_s7 <= (up_s6 - b3_s6) * (C50000 >> oss_q);
			b5_s7 <= b5_s6;
		end
	end

	logic big7;
	assign big7 = (b7_s7 >= SignBit);

	logic                pdv;
	logic [31:0]         pq;
	logic [DivSideW-1:0] pside;
	bsc_div u_pdiv (
		.clk, .arst_n, .en,
		.in_valid (v_s7), .num (big7 ? b7_s7 : (b7_s7 << 1)), .den (b4_s7),
		.side_in  ({32'd0, big7, b4_s7 == 32'd0, b5_s7}),
		.out_valid(pdv), .quo (pq), .side_out (pside)
	);

	// Stage 8: quotient fix-up and first correction products.
	logic        v_s8;
	logic [31:0] p_s8, sqp_s8, x2c_s8, b5_s8;
	logic [31:0] pr, ph;
	always_comb begin
		pr = pside[32] ? 32'hFFFF_FFFF : pq;
		if (pside[33]) pr = pr << 1;
		ph = asr(pr, 8);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= pdv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s8   <= pr;
			sqp_s8 <= ph * ph;
			x2c_s8 <= asr(pr * CNeg7357, 16);
			b5_s8  <= pside[31:0];
		end
	end

	// Stage 9: final correction.
	logic        v_s9;
	logic [31:0] p_s9, b5_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s9  <= p_s8 + asr(asr(sqp_s8 * C3038, 16) + x2c_s8 + C3791, 4);
			b5_s9 <= b5_s8;
		end
	end

	// Output register: saturation.
	logic [31:0] tt;
	logic [15:0] tsat;
	logic [19:0] psat;
	always_comb begin
		tt = asr(b5_s9 + 32'd8, 4);
		if ($signed(tt) > 32'sd32767) tsat = 16'h7FFF;
		else if ($signed(tt) < -32'sd32768) tsat = 16'h8000;
		else tsat = tt[15:0];
		if (p_s9[31]) psat = 20'd0;
		else if (p_s9 > {12'd0, PressMax}) psat = PressMax;
		else psat = p_s9[19:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {4'd0, psat, tsat};
			m_tuser <= invalid;
		end
	end

	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed during stall");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow pipeline enable");
	ap_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s9) && $stable(v_s3))
		else $error("pipeline moved while stalled");
	ap_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:36] == 4'd0)
		else $error("padding bits set");

endmodule

// ----- bench/tb_barometric_sensor_compensation_unit.sv -----
module tb_barometric_sensor_compensation_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import bsc_pkg::*;

	typedef struct {
		logic [15:0] temp;
		logic [19:0] press;
		logic        bad;
	} sample_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;

	logic [31:0] coef [5];
	logic [1:0]  oss;
	sample_t     expected_samples [$];
	int          errors;
	int          sent;
	int          received;
	bit          hold_output;

	barometric_sensor_compensation_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] ext16(logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	function automatic logic [31:0] sra(logic [31:0] v, int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic is_garbage(logic [15:0] h);
		return h == 16'h0000 || h == 16'hFFFF;
	endfunction

	function automatic sample_t compensate(logic [15:0] ut_in, logic [23:0] raw_p);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, t, sq, den;
		longint ts, ps;
		sample_t r;
		ac1 = ext16(coef[0][31:16]);
		ac2 = ext16(coef[0][15:0]);
		ac3 = ext16(coef[1][31:16]);
		ac4 = {16'd0, coef[1][15:0]};
		ac5 = {16'd0, coef[2][31:16]};
		ac6 = {16'd0, coef[2][15:0]};
		b1 = ext16(coef[3][31:16]);
		b2 = ext16(coef[3][15:0]);
		mc = ext16(coef[4][31:16]);
		md = ext16(coef[4][15:0]);
		r.bad = 1'b0;
		for (int i = 0; i < 5; i++)
			if (is_garbage(coef[i][31:16]) || is_garbage(coef[i][15:0]))
				r.bad = 1'b1;
		ut = {16'd0, ut_in};
		up = {8'd0, raw_p} >> (8 - oss);
		x1 = sra((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0)
			x2 = 32'hFFFFFFFF;
		else
			x2 = 32'($signed(mc << 11) / $signed(den));
		b5 = x1 + x2;
		t = sra(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x1 = sra(b2 * sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		b7 = (up - b3) * (32'd50000 >> oss);
		if (b7 < 32'h80000000)
			p = (b4 == 0) ? 32'hFFFFFFFF : (b7 * 32'd2) / b4;
		else
			p = ((b4 == 0) ? 32'hFFFFFFFF : b7 / b4) * 32'd2;
		x1 = sra(p, 8);
		x1 = x1 * x1;
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(p * (32'd0 - 32'd7357), 16);
		p = p + sra(x1 + x2 + 32'd3791, 4);
		ts = $signed(t);
		if (ts > 32767) ts = 32767;
		if (ts < -32768) ts = -32768;
		ps = $signed(p);
		if (ps > 1048575) ps = 1048575;
		if (ps < 0) ps = 0;
		r.temp = ts[15:0];
		r.press = ps[19:0];
		return r;
	endfunction

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_OSS)
			oss = val[1:0];
		else
			coef[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic load_coefs(logic [31:0] c0, c1, c2, c3, c4, logic [1:0] o);
		drain();
		write_reg(REG_AC1_AC2, c0);
		write_reg(REG_AC3_AC4, c1);
		write_reg(REG_AC5_AC6, c2);
		write_reg(REG_B1_B2, c3);
		write_reg(REG_MC_MD, c4);
		write_reg(REG_OSS, {30'd0, o});
	endtask

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_sample(logic [15:0] ut, logic [23:0] rp);
		s_tvalid <= 1'b1;
		s_tdata <= {rp, ut};
		do @(posedge clk); while (!s_tready);
		expected_samples.push_back(compensate(ut, rp));
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic send_burst(int n, bit realistic);
		int left;
		left = n;
		@(negedge clk);
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				if (realistic)
					send_sample(16'($urandom_range(20000, 40000)),
						24'($urandom_range(24'h500000, 24'hB00000)));
				else
					send_sample(16'($urandom), 24'($urandom));
			end
			if ($urandom_range(0, 3) != 0)
				idle_gap();
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic test_directed();
		logic [15:0] uts [6] = '{16'h0000, 16'hFFFF, 16'd27898, 16'h8000, 16'h7FFF, 16'd1};
		logic [23:0] ups [6] = '{24'h000000, 24'hFFFFFF, 24'h5D2300, 24'h800000,
			24'h7FFFFF, 24'h000001};
		load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
			{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_sample(uts[i], ups[i]);
		s_tvalid <= 1'b0;
		// Zero registers: garbage calibration and both division-by-zero cases.
		load_coefs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 2'd3);
		@(negedge clk);
		for (int i = 0; i < 4; i++)
			send_sample(uts[i], ups[i]);
		s_tvalid <= 1'b0;
		load_coefs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 2'd3);
		@(negedge clk);
		for (int i = 0; i < 4; i++)
			send_sample(uts[i], ups[i]);
		s_tvalid <= 1'b0;
		load_coefs({16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF},
			{16'h8000, 16'h0001}, {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, 2'd1);
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_sample(uts[i], ups[i]);
		s_tvalid <= 1'b0;
	endtask

	task automatic test_oversampling();
		for (int o = 0; o < 4; o++) begin
			load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
				{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'(o));
			send_burst(40, 1);
		end
	endtask

	task automatic test_random_coefs();
		for (int k = 0; k < 4; k++) begin
			load_coefs($urandom, $urandom, $urandom, $urandom, $urandom,
				2'($urandom_range(0, 3)));
			send_burst(30, k[0]);
		end
	endtask

	task automatic test_backpressure();
		load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
			{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd2);
		hold_output = 1'b1;
		fork
			send_burst(150, 1);
			begin
				repeat (300) @(negedge clk);
				hold_output = 1'b0;
			end
		join
	endtask

	always @(negedge clk) begin
		if (hold_output)
			m_tready <= 1'b0;
		else
			case ($urandom_range(0, 15))
				0, 1, 2: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sample_t exp_s;
			received++;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				exp_s = expected_samples.pop_front();
				if (m_tdata[15:0] !== exp_s.temp) begin
					$display("%0t: temperature expected %0d actual %0d", $time,
						$signed(exp_s.temp), $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[35:16] !== exp_s.press) begin
					$display("%0t: pressure expected %0d actual %0d", $time,
						exp_s.press, m_tdata[35:16]);
					errors++;
				end
				if (m_tuser !== exp_s.bad) begin
					$display("%0t: calibration flag expected %b actual %b", $time,
						exp_s.bad, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_output = 1'b0;
		errors = 0;
		sent = 0;
		received = 0;
		for (int i = 0; i < 5; i++)
			coef[i] = '0;
		oss = 2'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_oversampling();
		test_random_coefs();
		test_backpressure();
		drain();
		$display("Sent %0d samples, checked %0d results over all oversampling", sent, received);
		$display("settings, extreme and random calibrations, and a long output stall.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
